@@ hw/rtl/pmtg_pkg.sv @@
// Package for the priority melody tone generator.
// Holds the shared widths, build-time constants, register codes and pipeline structs.
// Has no dependencies; every other file in hw/rtl uses it.
package pmtg_pkg;

	localparam int SAMPLE_RATE_HZ   = 44100;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int PHASE_BITS       = 32;

	localparam int ADDR_BITS     = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR_IDX_BITS  = ADDR_BITS - 1;
	localparam int MAG_BITS      = 15;
	localparam int AMP_BITS      = 15;
	localparam int NSAMP_BITS    = 24;
	localparam int SAMPLE_BITS   = 16;
	localparam int REQ_BITS      = 2;
	localparam int NOTE_BITS     = 2;
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE    = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NOTE_SAMPLES = 8'd1;

	localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET    = 15'd8192;
	localparam logic [NSAMP_BITS-1:0] NOTE_SAMPLES_RESET = 24'd22050;

	typedef logic [PHASE_BITS-1:0] phase_t;

	// Per-item flags that travel with the sample through the pipeline.
	typedef struct packed {
		logic                 sounding;
		logic                 melody_sel;
		logic [NOTE_BITS-1:0] note_pos;
		logic                 note_done;
	} tone_info_t;

	// Stage load enables, one per pipeline register.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_en_t;

endpackage

@@ hw/rtl/pmtg_if.sv @@
// Channel interfaces of the priority melody tone generator: request, tone and config write.
// Each carries valid, ready and payload, with source and sink modports.
// Depends on pmtg_pkg for the field widths.
interface pmtg_req_if;
	logic                         valid;
	logic                         ready;
	logic [pmtg_pkg::REQ_BITS-1:0] hall_request;
	logic [pmtg_pkg::REQ_BITS-1:0] solenoid_request;

	modport source (output valid, output hall_request, output solenoid_request, input ready);
	modport sink   (input valid, input hall_request, input solenoid_request, output ready);
endinterface

interface pmtg_tone_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pmtg_pkg::SAMPLE_BITS-1:0] sample;
	logic                                  sounding;
	logic                                  melody_sel;
	logic [pmtg_pkg::NOTE_BITS-1:0]        note_pos;
	logic                                  note_done;

	modport source (output valid, output sample, output sounding, output melody_sel,
		output note_pos, output note_done, input ready);
	modport sink   (input valid, input sample, input sounding, input melody_sel,
		input note_pos, input note_done, output ready);
endinterface

interface pmtg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pmtg_pkg::CFG_IDX_BITS-1:0]  index;
	logic [pmtg_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pmtg_sine_rom.sv @@
// Quarter-wave sine ROM with registered read for the tone generator.
// The table is built at elaboration; the quadrant fold and sign are handled here.
// Depends on pmtg_pkg.
module pmtg_sine_rom (
	input  logic                             clk,
	input  logic                             en,
	input  logic [pmtg_pkg::ADDR_BITS-1:0]   addr,
	output logic [pmtg_pkg::MAG_BITS-1:0]    mag,
	output logic                             neg
);

	localparam int QTR_DEPTH = pmtg_pkg::SINE_TABLE_DEPTH / 4;
	localparam int MAG_W     = pmtg_pkg::MAG_BITS;
	localparam int IDX_W     = pmtg_pkg::QTR_IDX_BITS;
	localparam longint unsigned QtrDepth  = longint'(QTR_DEPTH);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          ONE_Q30     = 64'sd1073741824;

	typedef logic [QTR_DEPTH:0][MAG_W-1:0] qtab_t;

	// Q15 magnitude of sin(pi/2 * m / QTR_DEPTH) from a Q30 Taylor series.
	function automatic logic [MAG_W-1:0] qsine(input longint unsigned m);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x    = (HALF_PI_Q30 * m) / QtrDepth;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		return MAG_W'(($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic qtab_t build_table();
		qtab_t t;
		for (int m = 0; m <= QTR_DEPTH; m++) begin
			t[m] = qsine(longint'(m));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_table();

	logic [1:0]       quad;
	logic [IDX_W-1:0] low;
	logic [IDX_W-1:0] idx;

	assign quad = addr[pmtg_pkg::ADDR_BITS-1 -: 2];
	assign low  = {1'b0, addr[pmtg_pkg::ADDR_BITS-3:0]};
	// Odd quadrants run the quarter wave backwards.
	assign idx  = quad[0] ? (IDX_W'(QTR_DEPTH) - low) : low;

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= QTAB[idx];
			neg <= quad[1];
		end
	end

endmodule

@@ hw/rtl/pmtg_amp_scale.sv @@
// Amplitude scaling for the tone generator: multiply, then exact divide by full scale.
// Two pipeline registers (_s2 product, _s3 sample), loaded by the top level's enables.
// Depends on pmtg_pkg.
module pmtg_amp_scale (
	input  logic                                   clk,
	input  pmtg_pkg::pipe_en_t                     en,
	input  logic [pmtg_pkg::MAG_BITS-1:0]          mag,
	input  logic                                   neg,
	input  logic [pmtg_pkg::AMP_BITS-1:0]          amplitude,
	output logic signed [pmtg_pkg::SAMPLE_BITS-1:0] sample
);

	localparam int PROD_W = pmtg_pkg::MAG_BITS + pmtg_pkg::AMP_BITS;
	localparam int HALF_W = PROD_W / 2;
	localparam int SUM_W  = HALF_W + 1;
	localparam logic [SUM_W-1:0] FULL_SCALE = SUM_W'((1 << HALF_W) - 1);
	localparam logic [SUM_W-1:0] TWO_FULL   = SUM_W'(2 * ((1 << HALF_W) - 1));

	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;
	logic [SUM_W-1:0]  part_sum;
	logic [SUM_W-1:0]  quot;

	always_ff @(posedge clk) begin
		if (en.en2) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(amplitude);
			neg_s2  <= neg;
		end
	end

	// Division by 2^15-1: with p = a*2^15 + b, p/(2^15-1) = a + (a+b)/(2^15-1),
	// and a+b stays below three times the divisor.
	always_comb begin
		part_sum = SUM_W'(prod_s2[PROD_W-1:HALF_W]) + SUM_W'(prod_s2[HALF_W-1:0]);
		quot     = SUM_W'(prod_s2[PROD_W-1:HALF_W]);
		if (part_sum >= TWO_FULL) begin
			quot = quot + SUM_W'(2);
		end else if (part_sum >= FULL_SCALE) begin
			quot = quot + SUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			sample <= neg_s2 ? -$signed(pmtg_pkg::SAMPLE_BITS'(quot))
			                 : $signed(pmtg_pkg::SAMPLE_BITS'(quot));
		end
	end

endmodule

@@ hw/rtl/priority_melody_tone_generator_top.sv @@
// Top level of the priority melody tone generator (DDS sine tone with melody sequencing).
// Instantiates pmtg_sine_rom and pmtg_amp_scale; uses pmtg_pkg and the pmtg_*_if interfaces.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------------
//   request  | in  | valid / ready | hall_request[1:0], solenoid_request[1:0]
//   tone     | out | valid / ready | sample[15:0] signed, sounding, melody_sel,
//            |     |               | note_pos[1:0], note_done
//   cfg      | in  | valid / ready | index[7:0], data[23:0] (ready is always high)
//
// One request transfer can be taken every clock cycle while the tone output is not
// stalled, and each gives exactly one tone transfer through the ROM, multiply and divide
// stage registers. The rate is set by the note state update (phase add and sample count
// compare), which closes on itself through the note state registers.
// Reset clears the note state and the stage valid bits and loads the two config registers with their reset values.
// A stalled tone output holds its register; bubbles in front of it still collapse, so
// requests keep flowing until every stage is full.
module priority_melody_tone_generator_top (
	input  logic              clk,
	input  logic              arst_n,
	pmtg_req_if.sink          request,
	pmtg_tone_if.source       tone,
	pmtg_cfg_if.sink          cfg
);

	localparam int PB = pmtg_pkg::PHASE_BITS;
	localparam int NB = pmtg_pkg::NSAMP_BITS;
	localparam longint unsigned SampleRate = longint'(pmtg_pkg::SAMPLE_RATE_HZ);

	// Phase step per sample for a note of hz, rounded to nearest.
	function automatic pmtg_pkg::phase_t phase_inc(input longint unsigned hz);
		longint unsigned num;
		num = (hz << PB) + (SampleRate / 2);
		return PB'(num / SampleRate);
	endfunction

	localparam pmtg_pkg::phase_t PHASE_INC [2][4] = '{
		'{phase_inc(262), phase_inc(294), phase_inc(330), phase_inc(349)},
		'{phase_inc(392), phase_inc(440), phase_inc(494), phase_inc(523)}
	};

	// Configuration registers. Writes to unknown indexes are dropped.
	logic [pmtg_pkg::AMP_BITS-1:0] amplitude_q;
	logic [NB-1:0]                 note_samples_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q    <= pmtg_pkg::AMPLITUDE_RESET;
			note_samples_q <= pmtg_pkg::NOTE_SAMPLES_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				pmtg_pkg::REG_AMPLITUDE: begin
					amplitude_q <= cfg.data[pmtg_pkg::AMP_BITS-1:0];
				end
				pmtg_pkg::REG_NOTE_SAMPLES: begin
					note_samples_q <= cfg.data[NB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or the one after it moves.
	pmtg_pkg::pipe_en_t en;
	logic v_s1, v_s2, v_s3;
	logic accept;

	assign en.en3      = !v_s3 || tone.ready;
	assign en.en2      = !v_s2 || en.en3;
	assign en.en1      = !v_s1 || en.en2;
	assign request.ready = en.en1;
	assign accept      = request.valid && en.en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.en1) begin
				v_s1 <= request.valid;
			end
			if (en.en2) begin
				v_s2 <= v_s1;
			end
			if (en.en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Note state.
	logic                          playing_q;
	logic                          melody_q;
	logic [pmtg_pkg::NOTE_BITS-1:0] note_idx_q;
	logic [NB-1:0]                 count_q;
	pmtg_pkg::phase_t              phase_acc_q;

	logic [pmtg_pkg::REQ_BITS-1:0] any_req;
	logic                          has_req;
	logic                          active;
	logic                          mel;
	pmtg_pkg::phase_t              phase_use;
	logic [NB-1:0]                 count_use;
	logic [NB-1:0]                 note_len;
	logic [NB:0]                   count_inc;
	logic                          done;
	pmtg_pkg::tone_info_t          info_s0;

	// An idle block starts a note on any request; sensor 0 wins and picks melody 0.
	// The starting tick sounds with phase zero and a fresh sample count.
	always_comb begin
		any_req   = request.hall_request | request.solenoid_request;
		has_req   = (any_req != '0);
		active    = playing_q || has_req;
		mel       = playing_q ? melody_q : !any_req[0];
		phase_use = playing_q ? phase_acc_q : '0;
		count_use = playing_q ? count_q : '0;
		// A note length of zero behaves as one sample.
		note_len  = (note_samples_q == '0) ? NB'(1) : note_samples_q;
		count_inc = {1'b0, count_use} + (NB + 1)'(1);
		// Compare with >= so a length shortened mid-note ends the note right away.
		done      = active && (count_inc >= {1'b0, note_len});

		info_s0.sounding   = active;
		info_s0.melody_sel = active && mel;
		info_s0.note_pos   = active ? note_idx_q : '0;
		info_s0.note_done  = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q   <= 1'b0;
			melody_q    <= 1'b0;
			note_idx_q  <= '0;
			count_q     <= '0;
			phase_acc_q <= '0;
		end else if (accept && active) begin
			playing_q   <= !done;
			melody_q    <= mel;
			phase_acc_q <= phase_use + PHASE_INC[mel][note_idx_q];
			count_q     <= done ? '0 : count_inc[NB-1:0];
			// The note index survives melody changes; it resets only when requests stop.
			if (done) begin
				note_idx_q <= has_req ? note_idx_q + pmtg_pkg::NOTE_BITS'(1) : '0;
			end
		end
	end

	// Stage 1: ROM lookup at the top bits of the phase used for this tick.
	logic [pmtg_pkg::MAG_BITS-1:0] mag_s1;
	logic                          neg_s1;
	pmtg_pkg::tone_info_t          info_s1, info_s2, info_s3;

	pmtg_sine_rom u_rom (
		.clk  (clk),
		.en   (en.en1),
		.addr (phase_use[PB-1 -: pmtg_pkg::ADDR_BITS]),
		.mag  (mag_s1),
		.neg  (neg_s1)
	);

	// Stages 2 and 3: amplitude multiply, then divide and sign.
	logic signed [pmtg_pkg::SAMPLE_BITS-1:0] sample_s3;

	pmtg_amp_scale u_scale (
		.clk       (clk),
		.en        (en),
		.mag       (mag_s1),
		.neg       (neg_s1),
		.amplitude (amplitude_q),
		.sample    (sample_s3)
	);

	always_ff @(posedge clk) begin
		if (en.en1) begin
			info_s1 <= info_s0;
		end
		if (en.en2) begin
			info_s2 <= info_s1;
		end
		if (en.en3) begin
			info_s3 <= info_s2;
		end
	end

	// Silent ticks show a zero sample whatever the ROM path carried.
	assign tone.valid      = v_s3;
	assign tone.sample     = info_s3.sounding ? sample_s3 : '0;
	assign tone.sounding   = info_s3.sounding;
	assign tone.melody_sel = info_s3.melody_sel;
	assign tone.note_pos   = info_s3.note_pos;
	assign tone.note_done  = info_s3.note_done;

endmodule

@@ hw/rtl/pmtg_checker.sv @@
// Port-level checker for the priority melody tone generator, attached by bind.
// Watches the tone output channel; depends on pmtg_pkg for the widths.
module pmtg_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   tone_valid,
	input logic                                   tone_ready,
	input logic signed [pmtg_pkg::SAMPLE_BITS-1:0] tone_sample,
	input logic                                   tone_sounding,
	input logic                                   tone_melody_sel,
	input logic [pmtg_pkg::NOTE_BITS-1:0]         tone_note_pos,
	input logic                                   tone_note_done
);

	// A result that is not taken stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && !tone_ready |=> tone_valid && $stable(tone_sample)
			&& $stable(tone_note_done))
		else $error("tone output changed while stalled");

	// Silent results carry no sample, melody, position or note end.
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && !tone_sounding |-> tone_sample == '0 && !tone_melody_sel
			&& tone_note_pos == '0 && !tone_note_done)
		else $error("silent result with nonzero fields");

	// Samples stay within symmetric full scale.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid |-> tone_sample != 16'sh8000)
		else $error("sample outside symmetric range");

	// A taken sounding result that does not end its note is followed by another sample
	// of the same note, so a result shown in the next cycle keeps the position.
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && tone_ready && tone_sounding && !tone_note_done
			##1 tone_valid && tone_sounding
			|-> tone_note_pos == $past(tone_note_pos))
		else $error("note position changed within a note");

endmodule

bind priority_melody_tone_generator_top pmtg_checker u_pmtg_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.tone_valid      (tone.valid),
	.tone_ready      (tone.ready),
	.tone_sample     (tone.sample),
	.tone_sounding   (tone.sounding),
	.tone_melody_sel (tone.melody_sel),
	.tone_note_pos   (tone.note_pos),
	.tone_note_done  (tone.note_done)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for priority_melody_tone_generator_top.
// Uses pmtg_pkg and the pmtg_req_if, pmtg_tone_if and pmtg_cfg_if interfaces.
// A directed table comes first, then random request traffic checked against a tone predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmtg_pkg::*;

	// The run is stopped as failed if it has not ended after this many cycles.
	localparam int LIMIT_CYCLES     = 200000;
	// The receiver holds off this long once, so the pipeline fills and stalls requests.
	localparam int LONG_HOLD_CYCLES = 100;
	// Extra cycles run after the last tone has been taken from the three-stage pipeline.
	localparam int SETTLE_CYCLES    = 8;
	localparam int DIR_ROWS         = 29;
	localparam int SEGMENTS         = 6;
	// An index that maps to no register; a write to it must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_OF_RANGE = 8'hA5;

	localparam int unsigned NOTE_HZ [2][4] = '{'{262, 294, 330, 349}, '{392, 440, 494, 523}};

	typedef longint unsigned u64_t;

	// One tone transfer as seen on the output channel.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		tone_info_t                    info;
	} tone_rec_t;

	// One row of the directed table: either a register write or a request transfer.
	// When typed is set, want holds the tone that the row must give.
	typedef struct packed {
		logic                     is_reg;
		logic [CFG_IDX_BITS-1:0]  reg_idx;
		logic [CFG_DATA_BITS-1:0] reg_data;
		logic [REQ_BITS-1:0]      hall;
		logic [REQ_BITS-1:0]      sol;
		logic                     typed;
		tone_rec_t                want;
	} stim_row_t;

	// Settings and handshake pressure for one stretch of random traffic.
	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] amp_data;
		logic [CFG_DATA_BITS-1:0] ns_data;
		int                       send_pct;
		int                       recv_pct;
		int                       items;
	} seg_plan_t;

	logic clk;
	logic arst_n;

	pmtg_req_if  req_ch ();
	pmtg_tone_if tone_ch ();
	pmtg_cfg_if  cfg_ch ();

	priority_melody_tone_generator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.tone    (tone_ch),
		.cfg     (cfg_ch)
	);

	// Sine lookup and per-note phase steps, filled in at time zero.
	logic [MAG_BITS-1:0] rom_mag [SINE_TABLE_DEPTH];
	logic                rom_neg [SINE_TABLE_DEPTH];
	phase_t              note_step [2][4];

	// Mirror of the block's registers and note state.
	logic [AMP_BITS-1:0]   amp_reg   = AMPLITUDE_RESET;
	logic [NSAMP_BITS-1:0] nsamp_reg = NOTE_SAMPLES_RESET;
	logic                  note_on    = 1'b0;
	logic                  cur_melody = 1'b0;
	logic [NOTE_BITS-1:0]  cur_note   = '0;
	logic [NSAMP_BITS-1:0] note_count = '0;
	phase_t                phase      = '0;

	// Tones that accepted requests have yet to produce, oldest first.
	tone_rec_t tones_due [$];

	int send_idle_pct = 9;
	int recv_idle_pct = 45;
	bit long_hold_go   = 1'b0;
	bit long_hold_done = 1'b0;

	int errors        = 0;
	int requests_sent = 0;
	int tones_seen    = 0;
	int notes_ended   = 0;
	int upper_notes   = 0;
	int peak_mag      = 0;
	int reg_writes    = 0;

	// Magnitude of sin(pi/2 * num / den) in Q15, from a Q30 Taylor series.
	function automatic int unsigned quarter_mag(input longint unsigned num,
		input longint unsigned den);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint unsigned n;
		x = (64'd1686629713 * num) / den;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = term / ((2 * n) * (2 * n + 1));
			if (n[0])
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > (longint'(1) << 30))
			acc = longint'(1) << 30;
		return int'((u64_t'(acc) * 32767 + (64'd1 << 29)) >> 30);
	endfunction

	// Advances the note state by one sample tick and returns the tone it gives.
	function automatic tone_rec_t synth_tone(input logic [REQ_BITS-1:0] hall,
		input logic [REQ_BITS-1:0] sol);
		logic [REQ_BITS-1:0] req_any;
		int unsigned         addr;
		longint unsigned     scaled;
		longint unsigned     span;
		tone_rec_t           rec;
		req_any = hall | sol;
		rec = '0;
		if (!note_on) begin
			// Silent with nothing requested: the tick is empty and nothing moves.
			if (req_any == '0)
				return rec;
			// The lowest sensor with any request picks the melody.
			cur_melody = ~req_any[0];
			note_on = 1'b1;
			note_count = '0;
			phase = '0;
		end
		addr = int'((u64_t'(phase) * SINE_TABLE_DEPTH) >> PHASE_BITS);
		scaled = (u64_t'(rom_mag[addr]) * amp_reg) / 32767;
		rec.sample = rom_neg[addr] ? -SAMPLE_BITS'(scaled) : SAMPLE_BITS'(scaled);
		rec.info.sounding = 1'b1;
		rec.info.melody_sel = cur_melody;
		rec.info.note_pos = cur_note;
		phase = phase + note_step[cur_melody][cur_note];
		// A length of zero behaves as one sample.
		span = (nsamp_reg == '0) ? 1 : nsamp_reg;
		if (u64_t'(note_count) + 1 >= span) begin
			rec.info.note_done = 1'b1;
			cur_note = (req_any != '0) ? cur_note + 1'b1 : '0;
			note_on = 1'b0;
			note_count = '0;
		end else begin
			note_count = note_count + 1'b1;
		end
		return rec;
	endfunction

	function automatic stim_row_t item_row(input logic [REQ_BITS-1:0] hall,
		input logic [REQ_BITS-1:0] sol);
		stim_row_t row;
		row = '0;
		row.hall = hall;
		row.sol = sol;
		return row;
	endfunction

	// A request row whose tone is known by inspection; every such tone has a zero sample.
	function automatic stim_row_t check_row(input logic [REQ_BITS-1:0] hall,
		input logic [REQ_BITS-1:0] sol, input logic snd, input logic mel,
		input logic [NOTE_BITS-1:0] pos, input logic done);
		stim_row_t row;
		row = item_row(hall, sol);
		row.typed = 1'b1;
		row.want.info.sounding = snd;
		row.want.info.melody_sel = mel;
		row.want.info.note_pos = pos;
		row.want.info.note_done = done;
		return row;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		stim_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		return row;
	endfunction

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic wait_drained();
		while (tones_due.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the pipeline empty, so the write lands between ticks.
	// Valid stays high after the transfer; the next request lowers it.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		req_ch.valid <= 1'b0;
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_AMPLITUDE: begin
				amp_reg = data[AMP_BITS-1:0];
			end
			REG_NOTE_SAMPLES: begin
				nsamp_reg = data[NSAMP_BITS-1:0];
			end
			default: begin
			end
		endcase
		reg_writes++;
	endtask

	// Offers one request, with random gaps before it, and books its tone once the
	// transfer happens. Valid is left high so back-to-back requests need no toggle.
	task automatic offer_request(input logic [REQ_BITS-1:0] hall,
		input logic [REQ_BITS-1:0] sol, input logic typed, input tone_rec_t want);
		tone_rec_t rec;
		cfg_ch.valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.hall_request     <= hall;
		req_ch.solenoid_request <= sol;
		do @(posedge clk); while (!req_ch.ready);
		rec = synth_tone(hall, sol);
		tones_due.push_back(typed ? want : rec);
		requests_sent++;
	endtask

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver side: random back-pressure, plus one long hold-off while requests keep
	// coming, which fills every stage and forces the request ready low.
	initial begin : tone_receiver
		int k;
		tone_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_go && !long_hold_done) begin
				long_hold_done = 1'b1;
				tone_ch.ready <= 1'b0;
				for (k = 1; k < LONG_HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				tone_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Every tone transfer is matched against the oldest booked tone, field by field.
	always @(posedge clk) begin : tone_monitor
		tone_rec_t got;
		tone_rec_t want;
		int        mag_now;
		if (arst_n && tone_ch.valid && tone_ch.ready) begin
			got.sample = tone_ch.sample;
			got.info.sounding = tone_ch.sounding;
			got.info.melody_sel = tone_ch.melody_sel;
			got.info.note_pos = tone_ch.note_pos;
			got.info.note_done = tone_ch.note_done;
			tones_seen++;
			mag_now = (got.sample < 0) ? -int'(got.sample) : int'(got.sample);
			if (mag_now > peak_mag)
				peak_mag = mag_now;
			if (got.info.note_done) begin
				notes_ended++;
				if (got.info.melody_sel)
					upper_notes++;
			end
			if (tones_due.size() == 0) begin
				note_error($sformatf("tone %0d arrived with nothing pending: sample %0d",
					tones_seen, got.sample));
			end else begin
				want = tones_due.pop_front();
				if (got.sample !== want.sample || got.info.sounding !== want.info.sounding
					|| got.info.melody_sel !== want.info.melody_sel
					|| got.info.note_pos !== want.info.note_pos
					|| got.info.note_done !== want.info.note_done) begin
					note_error($sformatf({"tone %0d mismatch: expected sample %0d snd %0b ",
						"mel %0b pos %0d done %0b, got sample %0d snd %0b mel %0b pos %0d ",
						"done %0b"}, tones_seen, want.sample, want.info.sounding,
						want.info.melody_sel, want.info.note_pos, want.info.note_done,
						got.sample, got.info.sounding, got.info.melody_sel,
						got.info.note_pos, got.info.note_done));
				end
			end
		end
	end

	// Watchdog: a run that hangs on a handshake ends here.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		stim_row_t       dir_rows [DIR_ROWS];
		seg_plan_t       plan [SEGMENTS];
		longint unsigned k4;
		longint unsigned quad;
		longint unsigned rem;
		int              i;
		int              seg;
		int              sent;
		int              pick;
		int              run;
		int              k;
		logic [REQ_BITS-1:0] hall;
		logic [REQ_BITS-1:0] sol;

		// Build the sine lookup with quarter-wave symmetry and the note phase steps.
		for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
			k4 = longint'(i) * 4;
			quad = k4 / SINE_TABLE_DEPTH;
			rem = k4 % SINE_TABLE_DEPTH;
			if (quad[0])
				rem = SINE_TABLE_DEPTH - rem;
			rom_neg[i] = (quad >= 2);
			rom_mag[i] = MAG_BITS'(quarter_mag(rem, SINE_TABLE_DEPTH));
		end
		for (i = 0; i < 8; i++) begin
			k4 = (u64_t'(NOTE_HZ[i / 4][i % 4]) << PHASE_BITS) + SAMPLE_RATE_HZ / 2;
			note_step[i / 4][i % 4] = phase_t'(k4 / SAMPLE_RATE_HZ);
		end

		// Every input is known from the first instant.
		arst_n                  <= 1'b0;
		req_ch.valid            <= 1'b0;
		req_ch.hall_request     <= '0;
		req_ch.solenoid_request <= '0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.index            <= '0;
		cfg_ch.data             <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Notes start with phase zero, so a start tick always has a zero
		// sample, and with a one-sample note every tick is a start tick.
		dir_rows = '{
			// Silent and nothing requested: an all-zero tone, state kept.
			check_row(2'b00, 2'b00, 1'b0, 1'b0, 2'd0, 1'b0),
			reg_row(REG_NOTE_SAMPLES, 24'd2),
			// Only sensor 1 asks, so the upper melody starts at note 0.
			check_row(2'b10, 2'b00, 1'b1, 1'b1, 2'd0, 1'b0),
			// Second tick ends the note with no request, so the note index falls to 0.
			item_row(2'b00, 2'b00),
			check_row(2'b00, 2'b01, 1'b1, 1'b0, 2'd0, 1'b0),
			item_row(2'b11, 2'b11),
			// Sensor 0 wins over sensor 1; the note index carried over is 1.
			check_row(2'b01, 2'b10, 1'b1, 1'b0, 2'd1, 1'b0),
			item_row(2'b11, 2'b11),
			reg_row(REG_AMPLITUDE, 24'd32767),
			// A note length of zero acts as one sample.
			reg_row(REG_NOTE_SAMPLES, 24'd0),
			check_row(2'b00, 2'b10, 1'b1, 1'b1, 2'd2, 1'b1),
			check_row(2'b10, 2'b00, 1'b1, 1'b1, 2'd3, 1'b1),
			// The note index wraps from 3 back to 0.
			check_row(2'b01, 2'b00, 1'b1, 1'b0, 2'd0, 1'b1),
			reg_row(REG_NOTE_SAMPLES, 24'hFFFFFF),
			check_row(2'b11, 2'b00, 1'b1, 1'b0, 2'd1, 1'b0),
			// Mid-note requests do not change the melody that is playing.
			item_row(2'b10, 2'b01),
			item_row(2'b00, 2'b10),
			item_row(2'b10, 2'b10),
			item_row(2'b00, 2'b00),
			// Shortening the length below the count so far ends the note on the next tick.
			reg_row(REG_NOTE_SAMPLES, 24'd1),
			item_row(2'b00, 2'b00),
			// Only the low 15 bits of the amplitude write count, so this sets zero.
			reg_row(REG_AMPLITUDE, 24'hFF8000),
			// A write to an unused index changes nothing; notes stay one sample long.
			reg_row(REG_OUT_OF_RANGE, 24'd5),
			check_row(2'b10, 2'b10, 1'b1, 1'b1, 2'd0, 1'b1),
			check_row(2'b01, 2'b11, 1'b1, 1'b0, 2'd1, 1'b1),
			check_row(2'b11, 2'b01, 1'b1, 1'b0, 2'd2, 1'b1),
			reg_row(REG_NOTE_SAMPLES, 24'd4),
			check_row(2'b00, 2'b10, 1'b1, 1'b1, 2'd3, 1'b0),
			// Zero amplitude silences a sounding tick that is past its start.
			check_row(2'b00, 2'b00, 1'b1, 1'b1, 2'd3, 1'b0)
		};
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
			else
				offer_request(dir_rows[i].hall, dir_rows[i].sol, dir_rows[i].typed,
					dir_rows[i].want);
		end

		// Random part. Long notes sweep the whole sine, once at full scale; short ones churn
		// through note changes. Junk above bit 14 of some amplitude writes must be dropped.
		plan[0] = '{24'd32767, 24'd200, 9, 45, 130};
		plan[1] = '{{9'($urandom), 15'($urandom_range(1, 32766))},
			24'($urandom_range(1, 6)), 9, 45, 120};
		plan[2] = '{24'd1, 24'd3, 45, 9, 120};
		plan[3] = '{{9'($urandom), 15'($urandom)}, 24'd170, 45, 9, 120};
		plan[4] = '{24'd32767, 24'd2, 0, 0, 130};
		plan[5] = '{24'($urandom_range(0, 32767)), 24'($urandom_range(1, 16)), 0, 0, 130};

		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_reg(REG_AMPLITUDE, plan[seg].amp_data);
			write_reg(REG_NOTE_SAMPLES, plan[seg].ns_data);
			send_idle_pct = plan[seg].send_pct;
			recv_idle_pct = plan[seg].recv_pct;
			sent = 0;
			while (sent < plan[seg].items) begin
				pick = $urandom_range(0, 99);
				run = $urandom_range(1, 24);
				hall = REQ_BITS'($urandom);
				sol = REQ_BITS'($urandom);
				if (pick < 30) begin
					// Held request from sensor 1 only, which plays the upper melody.
					hall[0] = 1'b0;
					sol[0] = 1'b0;
					if ((hall | sol) == '0)
						hall[1] = 1'b1;
				end else if (pick < 70) begin
					// Held request that involves sensor 0.
					if (hall[0] == 1'b0)
						sol[0] = 1'b1;
				end else if (pick < 85) begin
					// Silence: notes end without a request and the index drops to 0.
					hall = '0;
					sol = '0;
				end
				for (k = 0; k < run && sent < plan[seg].items; k++) begin
					if (pick >= 85 || (pick < 70 && $urandom_range(0, 9) == 0)) begin
						// Noise, or a held request broken up for a tick.
						hall = REQ_BITS'($urandom);
						sol = REQ_BITS'($urandom);
					end
					if (seg == 0 && sent == 40)
						long_hold_go = 1'b1;
					if (seg == 2 && sent == 60) begin
						// The sender goes quiet until every booked tone is out.
						req_ch.valid <= 1'b0;
						wait_drained();
					end
					offer_request(hall, sol, 1'b0, '0);
					sent++;
				end
			end
		end

		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d tones over %0d register writes; %0d notes ended,",
			requests_sent, tones_seen, reg_writes, notes_ended);
		$display("%0d of them on the upper melody; largest sample magnitude %0d; %0d errors.",
			upper_notes, peak_mag, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
